// ===== sv/vmlc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmlc_pkg
// Shared types and constants for the minimum-length constraint pipeline.
// ----------------------------------------------------------------------------
package vmlc_pkg;

    localparam int POS_W   = 24;
    localparam int DIFF_W  = 25;
    localparam int MASS_W  = 24;
    localparam int MINSQ_W = 52;
    localparam int SQ_W    = 49;
    localparam int DIST_W  = 50;
    localparam int DEN_W   = 53;
    localparam int WDEN_W  = 25;
    localparam int Q_W     = 25;
    localparam int S_W     = 24;
    localparam int W_W     = 17;
    localparam int IN_W    = 248;
    localparam int OUT_W   = 152;

    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [DIFF_W-1:0] diff_t;

    typedef enum logic [1:0] {
        ST_APPLIED = 2'd0,
        ST_FAR     = 2'd1,
        ST_FIXED   = 2'd2
    } status_t;

    typedef struct packed {
        pos_t [2:0]         a;
        pos_t [2:0]         b;
        logic [MASS_W-1:0]  ia;
        logic [MASS_W-1:0]  ib;
        logic [MINSQ_W-1:0] minsq;
    } req_t;

    // payload carried alongside the dividers
    typedef struct packed {
        pos_t [2:0]  a;
        pos_t [2:0]  b;
        diff_t [2:0] d;
        status_t     status;
        logic        den_zero;
    } side_t;

    typedef struct packed {
        side_t              side;
        logic [DEN_W-1:0]   den;
        logic [MINSQ_W-1:0] minsq;
        logic [MASS_W-1:0]  ia;
        logic [WDEN_W-1:0]  wden;
    } div_req_t;

    localparam int SIDE_W = $bits(side_t);

endpackage

// ===== sv/vmlc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmlc_div
// Pipelined restoring divider, one quotient bit per stage, num <= den.
// ----------------------------------------------------------------------------
module vmlc_div #(
    parameter int NUM_W  = 52,
    parameter int DEN_W  = 53,
    parameter int Q_W    = 25,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo,
    output logic [SIDE_W-1:0] out_side
);
    localparam int REM_W = DEN_W + 1;

    logic [REM_W-1:0]  rem_reg  [Q_W];
    logic [Q_W-1:0]    q_reg    [Q_W];
    logic [DEN_W-1:0]  den_reg  [Q_W];
    logic [SIDE_W-1:0] side_reg [Q_W];
    logic [Q_W-1:0]    vld_reg;

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  rem_next;
        logic [Q_W-1:0]    q_next;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;
        logic              ge;

        if (j == 0) begin : g_first
            assign rem_in  = {{(REM_W-NUM_W){1'b0}}, num};
            assign den_in  = den;
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign rem_in  = {rem_reg[j-1][REM_W-2:0], 1'b0};
            assign den_in  = den_reg[j-1];
            assign side_in = side_reg[j-1];
            assign vld_in  = vld_reg[j-1];
        end

        always_comb begin
            ge       = rem_in >= {1'b0, den_in};
            rem_next = ge ? rem_in - {1'b0, den_in} : rem_in;
        end

        if (j == 0) begin : g_q0
            assign q_next = {{(Q_W-1){1'b0}}, ge};
        end else begin : g_qn
            assign q_next = {q_reg[j-1][Q_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
                den_reg[j]  <= den_in;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign quo       = q_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// ===== sv/vmlc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmlc_front
// Input register, deltas, squares, squared distance, status and denominators.
// ----------------------------------------------------------------------------
module vmlc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  vmlc_pkg::req_t    in_req,
    output logic              out_valid,
    output vmlc_pkg::div_req_t out_req
);
    import vmlc_pkg::*;

    req_t             in1_reg, in2_reg, in3_reg;
    diff_t [2:0]      d2_reg, d3_reg;
    logic [SQ_W-1:0]  sq_reg [3];
    div_req_t         out_reg;
    logic [3:0]       vld_reg;

    diff_t [2:0]      d_next;
    logic [SQ_W-1:0]  sq_next [3];
    logic [DIST_W-1:0] dist_sq;
    div_req_t         out_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d_next[k] = DIFF_W'($signed(in1_reg.a[k])) - DIFF_W'($signed(in1_reg.b[k]));
        end
        for (int k = 0; k < 3; k++) begin
            sq_next[k] = SQ_W'($signed(d2_reg[k]) * $signed(d2_reg[k]));
        end
    end

    always_comb begin
        dist_sq = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
        out_next.side.a = in3_reg.a;
        out_next.side.b = in3_reg.b;
        out_next.side.d = d3_reg;
        // distance check wins over the both-fixed check
        if ({2'b00, dist_sq} > in3_reg.minsq) begin
            out_next.side.status = ST_FAR;
        end else if (in3_reg.ia == '0 && in3_reg.ib == '0) begin
            out_next.side.status = ST_FIXED;
        end else begin
            out_next.side.status = ST_APPLIED;
        end
        out_next.den           = DEN_W'(dist_sq) + DEN_W'(in3_reg.minsq);
        out_next.side.den_zero = (dist_sq == '0) && (in3_reg.minsq == '0);
        out_next.minsq         = in3_reg.minsq;
        out_next.ia            = in3_reg.ia;
        out_next.wden          = WDEN_W'(in3_reg.ia) + WDEN_W'(in3_reg.ib);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in1_reg <= in_req;
            in2_reg <= in1_reg;
            d2_reg  <= d_next;
            in3_reg <= in2_reg;
            d3_reg  <= d2_reg;
            for (int k = 0; k < 3; k++) begin
                sq_reg[k] <= sq_next[k];
            end
            out_reg <= out_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_req   = out_reg;

endmodule

// ===== sv/vmlc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmlc_lane
// One axis: scale delta, split by mass weights, move and saturate.
// ----------------------------------------------------------------------------
module vmlc_lane (
    input  logic                      aclk,
    input  logic                      en,
    input  vmlc_pkg::diff_t           d,
    input  logic [vmlc_pkg::S_W-1:0]  s,
    input  logic [vmlc_pkg::W_W-1:0]  w1,
    input  logic [vmlc_pkg::W_W-1:0]  w2,
    input  vmlc_pkg::pos_t            a,
    input  vmlc_pkg::pos_t            b,
    input  logic                      pass,
    output vmlc_pkg::pos_t            new_a,
    output vmlc_pkg::pos_t            new_b
);
    import vmlc_pkg::*;

    localparam int PROD_W = 50;
    localparam int MOVE_W = 43;

    logic signed [PROD_W-1:0] prod_reg;
    diff_t                    sd_reg;
    logic signed [MOVE_W-1:0] ma_reg, mb_reg;
    pos_t                     a1_reg, a2_reg, a3_reg, b1_reg, b2_reg, b3_reg;
    logic [W_W-1:0]           w1_1_reg, w1_2_reg, w2_1_reg, w2_2_reg;
    logic                     pass1_reg, pass2_reg, pass3_reg;
    pos_t                     na_reg, nb_reg;

    logic signed [PROD_W-1:0] prod_next, prod_rnd;
    diff_t                    sd_next;
    logic signed [MOVE_W-1:0] ma_next, mb_next, ma_rnd, mb_rnd;
    logic signed [27:0]       sum_a, sum_b;
    pos_t                     na_next, nb_next;

    function automatic pos_t sat(input logic signed [27:0] v);
        pos_t r;
        if (v > 28'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -28'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        prod_next = PROD_W'($signed(d) * $signed({1'b0, s}));
        prod_rnd  = prod_reg + (PROD_W'(1) <<< 23);
        sd_next   = prod_rnd[48:24];
        ma_next   = MOVE_W'($signed(sd_reg) * $signed({1'b0, w1_2_reg}));
        mb_next   = MOVE_W'($signed(sd_reg) * $signed({1'b0, w2_2_reg}));
        ma_rnd    = ma_reg + (MOVE_W'(1) <<< 15);
        mb_rnd    = mb_reg + (MOVE_W'(1) <<< 15);
        sum_a     = 28'($signed(a3_reg)) + 28'($signed(ma_rnd[42:16]));
        sum_b     = 28'($signed(b3_reg)) - 28'($signed(mb_rnd[42:16]));
        na_next   = pass3_reg ? a3_reg : sat(sum_a);
        nb_next   = pass3_reg ? b3_reg : sat(sum_b);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            a1_reg    <= a;
            b1_reg    <= b;
            w1_1_reg  <= w1;
            w2_1_reg  <= w2;
            pass1_reg <= pass;
            sd_reg    <= sd_next;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            w1_2_reg  <= w1_1_reg;
            w2_2_reg  <= w2_1_reg;
            pass2_reg <= pass1_reg;
            ma_reg    <= ma_next;
            mb_reg    <= mb_next;
            a3_reg    <= a2_reg;
            b3_reg    <= b2_reg;
            pass3_reg <= pass2_reg;
            na_reg    <= na_next;
            nb_reg    <= nb_next;
        end
    end

    assign new_a = na_reg;
    assign new_b = nb_reg;

endmodule

// ===== sv/verlet_min_length_constraint.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// verlet_min_length_constraint
// Resolves one minimum-length constraint between two particles per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one constraint request (two positions, inverse masses and the
//   squared minimum length); m_* returns the corrected positions and status.
//   Status: applied, already far enough (pass-through), or both fixed
//   (pass-through). Positions are signed Q8.16 and saturate.
//   Request to result: 4 front stages, 25 stages of the bit-per-stage ratio
//   and weight dividers, one scale stage and 4 lane stages; the dividers set
//   the depth. A new request is taken every cycle unless a result is stalled.
//   Reset (aresetn low, synchronous) empties the pipeline; no results remain.
//   When the receiver holds m_tready low with a result waiting, the whole
//   pipeline holds and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module verlet_min_length_constraint (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, inv_mass_a, inv_mass_b, min_len_sq, pad
    input  logic [vmlc_pkg::IN_W-1:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z, status, pad
    output logic [vmlc_pkg::OUT_W-1:0] m_tdata
);
    import vmlc_pkg::*;

    logic     en;
    req_t     req;
    logic     fr_valid;
    div_req_t fr_req;
    logic     dv_valid;
    logic [Q_W-1:0] q_ratio, q_weight;
    logic [SIDE_W-1:0] side_bits;
    side_t    dv_side;

    side_t          sc_side_reg;
    logic [S_W-1:0] s_reg;
    logic [W_W-1:0] w1_reg, w2_reg;
    logic [S_W-1:0] s_next;
    logic [W_W-1:0] w1_next;
    logic [4:0]     vld_tail_reg;
    status_t        st_reg [4];

    pos_t [2:0] new_a, new_b;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            req.a[k] = s_tdata[k*POS_W +: POS_W];
            req.b[k] = s_tdata[(3+k)*POS_W +: POS_W];
        end
        req.ia    = s_tdata[144 +: MASS_W];
        req.ib    = s_tdata[168 +: MASS_W];
        req.minsq = s_tdata[192 +: MINSQ_W];
    end

    vmlc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_req   (req),
        .out_valid(fr_valid),
        .out_req  (fr_req)
    );

    vmlc_div #(
        .NUM_W (MINSQ_W),
        .DEN_W (DEN_W),
        .Q_W   (Q_W),
        .SIDE_W(SIDE_W)
    ) u_div_ratio (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (fr_valid),
        .num      (fr_req.minsq),
        .den      (fr_req.den),
        .in_side  (fr_req.side),
        .out_valid(dv_valid),
        .quo      (q_ratio),
        .out_side (side_bits)
    );

    // same depth as the ratio divider; the extra fraction bits are dropped
    vmlc_div #(
        .NUM_W (MASS_W),
        .DEN_W (WDEN_W),
        .Q_W   (Q_W),
        .SIDE_W(1)
    ) u_div_weight (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (fr_valid),
        .num      (fr_req.ia),
        .den      (fr_req.wden),
        .in_side  (1'b0),
        .out_valid(),
        .quo      (q_weight),
        .out_side ()
    );

    assign dv_side = side_t'(side_bits);

    always_comb begin
        s_next  = dv_side.den_zero ? '0 : S_W'(q_ratio - (Q_W'(1) << 23));
        w1_next = q_weight[Q_W-1:Q_W-W_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_tail_reg <= '0;
        end else if (en) begin
            vld_tail_reg <= {vld_tail_reg[3:0], dv_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_side_reg <= dv_side;
            s_reg       <= s_next;
            w1_reg      <= w1_next;
            w2_reg      <= W_W'(17'd65536) - w1_next;
            st_reg[0]   <= sc_side_reg.status;
            for (int k = 1; k < 4; k++) begin
                st_reg[k] <= st_reg[k-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        vmlc_lane u_lane (
            .aclk (aclk),
            .en   (en),
            .d    (sc_side_reg.d[k]),
            .s    (s_reg),
            .w1   (w1_reg),
            .w2   (w2_reg),
            .a    (sc_side_reg.a[k]),
            .b    (sc_side_reg.b[k]),
            .pass (sc_side_reg.status != ST_APPLIED),
            .new_a(new_a[k]),
            .new_b(new_b[k])
        );
    end

    assign m_tvalid = vld_tail_reg[4];
    assign m_tdata  = {6'd0, st_reg[3], new_b[2], new_b[1], new_b[0],
                       new_a[2], new_a[1], new_a[0]};

    st_never_3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[145:144] != 2'd3)
        else $error("reserved status code on output");

    reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    stall_holds_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> $stable(vld_tail_reg))
        else $error("pipeline moved while output stalled");

endmodule

// ===== bench/tb_verlet_min_length_constraint.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_verlet_min_length_constraint
// Streams constraint requests into the minimum-length constraint pipeline and
// checks every corrected position pair and status against a local predictor.
// ----------------------------------------------------------------------------
module tb_verlet_min_length_constraint;
    import vmlc_pkg::*;

    localparam int LATENCY   = 34;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 1600;
    localparam int HOLD_LEN  = 120;

    typedef struct {
        pos_t    pa [3];
        pos_t    pb [3];
        status_t st;
    } corr_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    req_t  pending_reqs [$];
    corr_t expected_corr [$];
    int    n_errors = 0;
    bit    stim_done = 1'b0;
    bit    quiet_tail = 1'b0;
    bit    long_hold = 1'b0;
    bit    drain_pause = 1'b0;
    int    wdog = 0;
    int    send_gap = 0;
    int    recv_gap = 0;
    int    hold_cnt = 0;

    always #5 aclk = ~aclk;

    verlet_min_length_constraint dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic longint rnd_half_up(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic pos_t clamp_pos(longint v);
        if (v > 64'sd8388607) return pos_t'(24'h7fffff);
        if (v < -64'sd8388608) return pos_t'(24'h800000);
        return pos_t'(v);
    endfunction

    function automatic corr_t constraint_solve(req_t r);
        corr_t c;
        longint d [3];
        longint unsigned d2, den, rem, q, s, w1, w2;
        longint sd, ma, mb;
        d2 = 0;
        s = 0;
        for (int k = 0; k < 3; k++) begin
            d[k] = longint'(r.a[2-k]) - longint'(r.b[2-k]);
            d2 += longint'(d[k] * d[k]);
            c.pa[k] = r.a[2-k];
            c.pb[k] = r.b[2-k];
        end
        if (d2 > r.minsq) begin
            c.st = ST_FAR;
        end else if (r.ia == 0 && r.ib == 0) begin
            c.st = ST_FIXED;
        end else begin
            c.st = ST_APPLIED;
            den = d2 + r.minsq;
            if (den != 0) begin
                q = 0;
                rem = r.minsq;
                if (rem >= den) begin
                    q = 1;
                    rem -= den;
                end
                for (int i = 0; i < 24; i++) begin
                    rem <<= 1;
                    q <<= 1;
                    if (rem >= den) begin
                        rem -= den;
                        q |= 1;
                    end
                end
                s = q - (64'd1 << 23);
            end
            w1 = (longint'(r.ia) << 16) / (longint'(r.ia) + longint'(r.ib));
            w2 = 65536 - w1;
            for (int k = 0; k < 3; k++) begin
                sd = rnd_half_up(d[k] * longint'(s), 24);
                ma = rnd_half_up(sd * longint'(w1), 16);
                mb = rnd_half_up(sd * longint'(w2), 16);
                c.pa[k] = clamp_pos(longint'(c.pa[k]) + ma);
                c.pb[k] = clamp_pos(longint'(c.pb[k]) - mb);
            end
        end
        return c;
    endfunction

    // struct keeps a_x at the top; tdata wants a_x in the low bits
    function automatic logic [IN_W-1:0] pack_req(req_t r);
        logic [IN_W-1:0] v;
        v = '0;
        for (int k = 0; k < 3; k++) begin
            v[k*24 +: 24] = r.a[2-k];
            v[(3+k)*24 +: 24] = r.b[2-k];
        end
        v[144 +: 24] = r.ia;
        v[168 +: 24] = r.ib;
        v[192 +: 52] = r.minsq;
        return v;
    endfunction

    function automatic pos_t rnd_pos();
        case ($urandom_range(0, 5))
            0: return pos_t'(24'h7fffff);
            1: return pos_t'(24'h800000);
            2: return pos_t'($urandom);
            default: return pos_t'($signed($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    function automatic logic [23:0] rnd_mass();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'hffffff;
            default: return 24'($urandom);
        endcase
    endfunction

    // mostly close particles whose minimum length exceeds their distance
    function automatic req_t rnd_req();
        req_t r;
        longint unsigned d2;
        longint dd;
        int near;
        near = ($urandom_range(0, 9) < 7);
        for (int k = 0; k < 3; k++) begin
            r.a[k] = rnd_pos();
            if (near)
                r.b[k] = clamp_pos(longint'(r.a[k]) +
                                   ($signed($urandom_range(0, 1 << 18)) - (1 << 17)));
            else
                r.b[k] = rnd_pos();
        end
        r.ia = rnd_mass();
        r.ib = rnd_mass();
        d2 = 0;
        for (int k = 0; k < 3; k++) begin
            dd = longint'(r.a[k]) - longint'(r.b[k]);
            d2 += dd * dd;
        end
        case ($urandom_range(0, 7))
            0: r.minsq = 52'({$urandom, $urandom});
            1: r.minsq = 52'(d2);
            2: r.minsq = '1;
            3: r.minsq = 52'(d2 > 0 ? d2 - 1 : 0);
            default: r.minsq = 52'(d2 + ({$urandom, $urandom} >> $urandom_range(12, 40)));
        endcase
        return r;
    endfunction

    function automatic req_t mk_req(pos_t ax, pos_t bx, logic [23:0] ia, logic [23:0] ib,
                                    logic [51:0] msq);
        req_t r;
        r.a[2] = ax; r.a[1] = ax; r.a[0] = ax;
        r.b[2] = bx; r.b[1] = bx; r.b[0] = bx;
        r.ia = ia;
        r.ib = ib;
        r.minsq = msq;
        return r;
    endfunction

    initial begin
        // coincident with zero minimum, equal distance, far, both fixed, one fixed
        pending_reqs.push_back(mk_req('0, '0, 24'h10000, 24'h10000, '0));
        pending_reqs.push_back(mk_req('0, 24'sd256, 24'h10000, 24'h10000, 52'd196608));
        pending_reqs.push_back(mk_req('0, 24'sd256, 24'h10000, 24'h10000, 52'd196607));
        pending_reqs.push_back(mk_req('0, 24'sd16, 24'd0, 24'd0, 52'd100000));
        pending_reqs.push_back(mk_req('0, 24'sd2000000, 24'd0, 24'd0, 52'd5));
        pending_reqs.push_back(mk_req('0, 24'sd16, 24'd0, 24'h8000, 52'd100000));
        pending_reqs.push_back(mk_req('0, 24'sd16, 24'h8000, 24'd0, 52'd100000));
        pending_reqs.push_back(mk_req('0, '0, 24'hffffff, 24'hffffff, '1));
        // saturation at both rails
        pending_reqs.push_back(mk_req(pos_t'(24'h7fffff), pos_t'(24'h7ffff0),
                                      24'h10000, 24'h10000, '1));
        pending_reqs.push_back(mk_req(pos_t'(24'h800000), pos_t'(24'h800010),
                                      24'hffffff, 24'h1, '1));
        pending_reqs.push_back(mk_req(pos_t'(24'h7fffff), pos_t'(24'h800000),
                                      24'h1, 24'hffffff, '1));
        pending_reqs.push_back(mk_req(pos_t'(24'h800000), pos_t'(24'h7fffff),
                                      24'h1, 24'h1, '1));
        for (int i = 0; i < 8; i++) pending_reqs.push_back(rnd_req());
        for (int i = 0; i < N_RANDOM / 2; i++) pending_reqs.push_back(rnd_req());
        // long receiver hold-off: the pipeline fills and s_tready drops
        wait (aresetn && pending_reqs.size() < N_RANDOM / 4);
        long_hold = 1'b1;
        wait (pending_reqs.size() == 0);
        drain_pause = 1'b1;
        wait (expected_corr.size() == 0 && !long_hold);
        drain_pause = 1'b0;
        for (int i = 0; i < N_RANDOM / 2; i++) pending_reqs.push_back(rnd_req());
        wait (pending_reqs.size() < 150);
        quiet_tail = 1'b1;
        wait (pending_reqs.size() == 0 && !(s_tvalid));
        stim_done = 1'b1;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // request driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_corr.push_back(constraint_solve(pending_reqs.pop_front()));
            end
            if (s_tvalid && !s_tready) begin
                // keep offering the same request
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (!quiet_tail && !drain_pause && $urandom_range(0, 7) == 0) begin
                send_gap <= $urandom_range(0, 3);
                s_tvalid <= 1'b0;
            end else if (!drain_pause && pending_reqs.size() > 0) begin
                // accepted request is already popped; the head is the next one
                s_tvalid <= 1'b1;
                s_tdata  <= pack_req(pending_reqs[0]);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge aclk) begin
        corr_t e;
        pos_t  got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_corr.size() == 0) begin
                    $error("unexpected result %h", m_tdata);
                    n_errors++;
                end else begin
                    e = expected_corr.pop_front();
                    for (int k = 0; k < 3; k++) begin
                        got = m_tdata[k*24 +: 24];
                        if (got !== e.pa[k]) begin
                            $error("new_a[%0d] expected %0d got %0d", k, e.pa[k], got);
                            n_errors++;
                        end
                        got = m_tdata[(3+k)*24 +: 24];
                        if (got !== e.pb[k]) begin
                            $error("new_b[%0d] expected %0d got %0d", k, e.pb[k], got);
                            n_errors++;
                        end
                    end
                    if (m_tdata[144 +: 2] !== e.st) begin
                        $error("status expected %0d got %0d", e.st, m_tdata[144 +: 2]);
                        n_errors++;
                    end
                end
            end
            if (long_hold) begin
                m_tready <= 1'b0;
                if (hold_cnt == HOLD_LEN) begin
                    long_hold <= 1'b0;
                    hold_cnt <= 0;
                end else begin
                    hold_cnt <= hold_cnt + 1;
                end
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                recv_gap <= $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog <= 0;
        else wdog <= wdog + 1;
    end

    initial begin
        wait (stim_done);
        wait (expected_corr.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (n_errors == 0) begin
            $display("tb_verlet_min_length_constraint: clean");
        end else begin
            $display("tb_verlet_min_length_constraint: errors");
        end
        $finish;
    end

    initial begin
        wait (wdog >= WDOG_MAX);
        $display("tb_verlet_min_length_constraint: errors");
        $finish;
    end

endmodule
